@@ hdl/dpr_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// dpr_pkg: shared types and constants for disparity reprojection
// Register indexes, field widths and the front-to-back item record.
// ============================================================================
package dpr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int DISP_W   = 20;
    localparam int FOCAL_W  = 24;
    localparam int BASE_W   = 20;
    localparam int DIM_W    = 13;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int PT_W     = 32;
    localparam int QDEPTH   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd6;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ZDIV,
        ST_XMUL,
        ST_XDIV,
        ST_YMUL,
        ST_YDIV,
        ST_DONE
    } bk_state_t;

    // classified item handed from front to back (positions Q.8 pixels)
    typedef struct packed {
        logic [DISP_W-2:0] disp;      // positive disparity magnitude
        logic              valid;
        logic              frame_end;
        logic signed [25:0] offs_x;   // u*256 - cx
        logic signed [25:0] offs_y;   // v*256 - cy
    } dpr_item_t;

endpackage

@@ hdl/dpr_divider.sv @@
`timescale 1ns / 1ps
// ============================================================================
// dpr_divider: unsigned restoring divider, one quotient bit per cycle
// Computes num / den for a 58-bit numerator and 24-bit divisor.
// ============================================================================
module dpr_divider
    import dpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [57:0] num,
    input  logic [23:0] den,
    output logic        done,
    output logic [57:0] quot
);

    logic [57:0] q_reg;
    logic [24:0] rem_reg;
    logic [23:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [24:0] trial;
    logic [25:0] diff;

    assign trial = {rem_reg[23:0], q_reg[57]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};

    // one shift-subtract step per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd57;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[25])
            begin
                rem_reg <= diff[24:0];
                q_reg   <= {q_reg[56:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[56:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

@@ hdl/dpr_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// dpr_front: pixel position tracking and item classification
// Keeps raster counters and builds the record for the back end.
// ============================================================================
module dpr_front
    import dpr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [DISP_W-1:0]  disparity,
    input  logic [FOCAL_W-1:0] center_x,
    input  logic [FOCAL_W-1:0] center_y,
    input  logic [DIM_W-1:0]   image_width,
    input  logic [DIM_W-1:0]   image_height,
    output dpr_item_t          item
);

    // compare width covers both the counter and the size register
    localparam int CNT_W = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 1;

    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic last_col, last_row;

    assign last_col = (CNT_W'(col_reg) + CNT_W'(1) >= CNT_W'(image_width))
                      || (&col_reg);
    assign last_row = (CNT_W'(row_reg) + CNT_W'(1) >= CNT_W'(image_height))
                      || (&row_reg);

    // raster advance
    always_comb
    begin
        col_next = col_reg + 1'b1;
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (take)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // classify current pixel
    always_comb
    begin
        item.valid     = !disparity[DISP_W-1] && (disparity != '0);
        item.disp      = disparity[DISP_W-2:0];
        item.frame_end = last_col && last_row;
        item.offs_x    = $signed(26'({col_reg, 8'd0}))
                         - $signed({2'b00, center_x});
        item.offs_y    = $signed(26'({row_reg, 8'd0}))
                         - $signed({2'b00, center_y});
    end

endmodule

@@ hdl/dpr_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// dpr_back: depth and lateral coordinate computation
// Sequences one shared divider through Z, X and Y for each valid item.
// ============================================================================
module dpr_back
    import dpr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  dpr_item_t          in_item,
    output logic               in_take,
    input  logic [FOCAL_W-1:0] focal_x,
    input  logic [FOCAL_W-1:0] focal_y,
    input  logic [BASE_W-1:0]  baseline,
    output logic               out_valid,
    input  logic               out_take,
    output logic [PT_W-1:0]    point_x,
    output logic [PT_W-1:0]    point_y,
    output logic [PT_W-1:0]    point_z,
    output logic               point_valid,
    output logic               frame_end
);

    bk_state_t st_reg, st_next;
    dpr_item_t it_reg;
    logic [30:0] z_reg;
    logic        neg_reg;
    logic [PT_W-1:0] x_reg, y_reg;
    logic        div_start;
    logic [57:0] div_num;
    logic [23:0] div_den;
    logic        div_done;
    logic [57:0] div_q;
    logic [23:0] fx1, fy1;
    logic [44:0] fxb;
    logic [25:0] offs_mag;
    logic [56:0] mul;
    logic [PT_W-1:0] lat;

    assign fx1 = (focal_x == '0) ? 24'd1 : focal_x;
    assign fy1 = (focal_y == '0) ? 24'd1 : focal_y;
    assign fxb = fx1 * baseline;

    // signed offset times depth, sign handled apart
    assign offs_mag = (st_reg == ST_XMUL) ?
        (it_reg.offs_x[25] ? 26'(-it_reg.offs_x) : 26'(it_reg.offs_x)) :
        (it_reg.offs_y[25] ? 26'(-it_reg.offs_y) : 26'(it_reg.offs_y));
    assign mul = offs_mag * z_reg;

    // saturate the magnitude quotient to a signed 32-bit value
    always_comb
    begin
        if (neg_reg)
            lat = (div_q > 58'h80000000) ? 32'h80000000 : 32'(-div_q[32:0]);
        else
            lat = (div_q > 58'h7FFFFFFF) ? 32'h7FFFFFFF : div_q[31:0];
    end

    dpr_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (in_valid) st_next = in_item.valid ? ST_ZDIV : ST_DONE;
            ST_ZDIV: if (div_done) st_next = ST_XMUL;
            ST_XMUL: st_next = ST_XDIV;
            ST_XDIV: if (div_done) st_next = ST_YMUL;
            ST_YMUL: st_next = ST_YDIV;
            ST_YDIV: if (div_done) st_next = ST_DONE;
            ST_DONE: if (out_take) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_take   = 1'b0;
        div_start = 1'b0;
        div_num   = {1'b0, mul};
        div_den   = fx1;
        unique case (st_reg)
            ST_IDLE:
            begin
                in_take   = in_valid;
                div_start = in_valid && in_item.valid;
                div_num   = 58'(fxb);
                div_den   = {5'd0, in_item.disp};
            end
            ST_XMUL: div_start = 1'b1;
            ST_YMUL:
            begin
                div_start = 1'b1;
                div_den   = fy1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_IDLE;
        else
            st_reg <= st_next;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_IDLE:
            begin
                it_reg <= in_item;
                z_reg  <= '0;
                x_reg  <= '0;
                y_reg  <= '0;
            end
            ST_ZDIV:
            begin
                if (div_done)
                begin
                    z_reg    <= (div_q > 58'h7FFFFFFF) ? 31'h7FFFFFFF : div_q[30:0];
                end
            end
            ST_XMUL, ST_YMUL:
            begin
                neg_reg  <= (st_reg == ST_XMUL) ? it_reg.offs_x[25] : it_reg.offs_y[25];
            end
            ST_XDIV: if (div_done) x_reg <= lat;
            ST_YDIV: if (div_done) y_reg <= lat;
            default: ;
        endcase
    end

    assign out_valid   = (st_reg == ST_DONE);
    assign point_x     = x_reg;
    assign point_y     = y_reg;
    assign point_z     = {1'b0, z_reg};
    assign point_valid = it_reg.valid;
    assign frame_end   = it_reg.frame_end;

endmodule

@@ hdl/disparity_to_point_reprojection_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// disparity_to_point_reprojection_core: disparity pixel to 3-D point
// Top level: config registers, front end, item queue and back end.
// ============================================================================
// Usage:
//   Input: drive disparity with push while full is low; one item per pixel
//   in raster order. Results: read point_x/y/z, point_valid and frame_end
//   while empty is low, and pulse pop to take the item.
//   Configuration: cfg_we with cfg_index and cfg_data, only while idle.
//   Processing: a valid pixel runs three 58-step divisions on one
//   shared bit-serial divider (Z, then X, then Y), and the back end takes
//   the next item only after pop takes the result. An invalid pixel skips
//   the divisions and goes straight to the result. The divider sets the rate.
//   A four-entry queue sits between the front end and the back end, so
//   pixels are taken while the back end works.
//   Reset clears the pixel counters, the queue and the registers to their
//   defaults. When pop is held low the result waits and the back end
//   stalls; the queue then fills and full rises.
// ============================================================================
module disparity_to_point_reprojection_core
    import dpr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [DISP_W-1:0]    disparity,
    output logic                 empty,
    input  logic                 pop,
    output logic [PT_W-1:0]      point_x,
    output logic [PT_W-1:0]      point_y,
    output logic [PT_W-1:0]      point_z,
    output logic                 point_valid,
    output logic                 frame_end,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int QA = $clog2(QDEPTH);

    logic [FOCAL_W-1:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [BASE_W-1:0]  baseline_reg;
    logic [DIM_W-1:0]   width_reg, height_reg;
    dpr_item_t          fr_item;
    dpr_item_t          q_mem [QDEPTH];
    logic [QA:0]        wp_reg, rp_reg;
    logic               take, q_empty, bk_take, bk_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= 24'd256;
            focal_y_reg  <= 24'd256;
            center_x_reg <= '0;
            center_y_reg <= '0;
            baseline_reg <= '0;
            width_reg    <= 13'd160;
            height_reg   <= 13'd120;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FOCAL_X:      focal_x_reg  <= cfg_data;
                REG_FOCAL_Y:      focal_y_reg  <= cfg_data;
                REG_CENTER_X:     center_x_reg <= cfg_data;
                REG_CENTER_Y:     center_y_reg <= cfg_data;
                REG_BASELINE:     baseline_reg <= cfg_data[BASE_W-1:0];
                REG_IMAGE_WIDTH:  width_reg    <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg   <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign full    = (wp_reg[QA] != rp_reg[QA]) && (wp_reg[QA-1:0] == rp_reg[QA-1:0]);
    assign q_empty = (wp_reg == rp_reg);
    assign take    = push && !full;

    dpr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .disparity    (disparity),
        .center_x     (center_x_reg),
        .center_y     (center_y_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .item         (fr_item)
    );

    // item queue between front and back
    always_ff @(posedge clk)
    begin
        if (take)
            q_mem[wp_reg[QA-1:0]] <= fr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (take)
                wp_reg <= wp_reg + 1'b1;
            if (bk_take)
                rp_reg <= rp_reg + 1'b1;
        end
    end

    dpr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (!q_empty),
        .in_item     (q_mem[rp_reg[QA-1:0]]),
        .in_take     (bk_take),
        .focal_x     (focal_x_reg),
        .focal_y     (focal_y_reg),
        .baseline    (baseline_reg),
        .out_valid   (bk_valid),
        .out_take    (pop),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .point_valid (point_valid),
        .frame_end   (frame_end)
    );

    assign empty = !bk_valid;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !(wp_reg == rp_reg)) else $error("queue full and empty");
    a_z_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !point_z[PT_W-1]) else $error("negative depth");
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !point_valid) |-> (point_z == '0 && point_x == '0))
        else $error("invalid point not zero");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(point_z)))
        else $error("result dropped while stalled");

endmodule
